// ----- sv/accid_pkg.sv -----
package accid_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int REF_W = 12;
    localparam int RES_W = 22;
    localparam int IDX_W = 4;
    localparam int TABLE_LEN = 15;
    localparam int DIV_STEP = 2;

    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_IDX_REF = 1'b0;
    localparam logic [REF_W-1:0] REF_RESET = REF_W'(510);

    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};
    localparam logic [IDX_W-1:0] IDX_NONE = '0;

    localparam logic [RES_W-1:0] LO_BOUND [TABLE_LEN] = '{
        RES_W'(43), RES_W'(51), RES_W'(62), RES_W'(75), RES_W'(91),
        RES_W'(110), RES_W'(135), RES_W'(165), RES_W'(200), RES_W'(245),
        RES_W'(300), RES_W'(360), RES_W'(430), RES_W'(516), RES_W'(620)
    };

    localparam logic [RES_W-1:0] HI_BOUND [TABLE_LEN] = '{
        RES_W'(51), RES_W'(62), RES_W'(75), RES_W'(91), RES_W'(110),
        RES_W'(135), RES_W'(165), RES_W'(200), RES_W'(245), RES_W'(300),
        RES_W'(360), RES_W'(430), RES_W'(515), RES_W'(620), RES_W'(750)
    };

    typedef struct packed {
        logic fault;
        logic zero;
    } res_flags_t;

    function automatic logic [IDX_W-1:0] classify(input logic [RES_W-1:0] r);
        logic [IDX_W-1:0] idx;
        idx = IDX_NONE;
        for (int k = TABLE_LEN - 1; k >= 0; k--)
        begin
            if (r > LO_BOUND[k] && r < HI_BOUND[k])
            begin
                idx = IDX_W'(k + 1);
            end
        end
        return idx;
    endfunction

endpackage

// ----- sv/accid_in_if.sv -----
interface accid_in_if
    import accid_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) ();

    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] sense_reading;
    logic [ADC_BITS-1:0] supply_reading;

    modport source (
        output valid,
        output sense_reading,
        output supply_reading,
        input  ready
    );

    modport sink (
        input  valid,
        input  sense_reading,
        input  supply_reading,
        output ready
    );

endinterface

// ----- sv/accid_out_if.sv -----
interface accid_out_if
    import accid_pkg::*;
();

    logic             valid;
    logic             ready;
    logic [RES_W-1:0] resistance;
    logic [IDX_W-1:0] module_index;
    logic             divide_fault;

    modport source (
        output valid,
        output resistance,
        output module_index,
        output divide_fault,
        input  ready
    );

    modport sink (
        input  valid,
        input  resistance,
        input  module_index,
        input  divide_fault,
        output ready
    );

endinterface

// ----- sv/accid_cfg.sv -----
module accid_cfg
    import accid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [REF_W-1:0]      ref_res
);

    logic [REF_W-1:0] ref_reg;
    logic             sel_ref;

    assign sel_ref = (paddr[CFG_ADDR_W-1] == REG_IDX_REF);
    assign pready  = 1'b1;
    assign prdata  = sel_ref ? APB_DATA_W'(ref_reg) : '0;
    assign ref_res = ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= REF_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_ref)
        begin
            ref_reg <= pwdata[REF_W-1:0];
        end
    end

endmodule

// ----- sv/accid_front.sv -----
module accid_front
    import accid_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int DEN_W    = ADC_BITS + 1,
    parameter int Q_W      = ADC_BITS + REF_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADC_BITS-1:0] sense,
    input  logic [ADC_BITS-1:0] supply,
    input  logic [REF_W-1:0]    ref_res,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DEN_W-1:0]    rem_out,
    output logic [Q_W-1:0]      work_out,
    output logic [DEN_W-1:0]    den_out,
    output res_flags_t          flags_out
);

    localparam int NUM_W = ADC_BITS + REF_W;

    logic                valid_reg;
    logic [Q_W-1:0]      work_reg;
    logic [DEN_W-1:0]    den_reg;
    res_flags_t          flags_reg;
    logic [DEN_W-1:0]    twice_b;
    logic [DEN_W-1:0]    a_ext;
    logic [NUM_W-1:0]    product;

    assign twice_b = {supply, 1'b0};
    assign a_ext   = DEN_W'(sense);
    assign product = NUM_W'(sense) * NUM_W'(ref_res);

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign rem_out   = '0;
    assign work_out  = work_reg;
    assign den_out   = den_reg;
    assign flags_out = flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg        <= Q_W'(product);
            den_reg         <= twice_b - a_ext;
            flags_reg.fault <= (twice_b == a_ext);
            flags_reg.zero  <= (twice_b < a_ext);
        end
    end

endmodule

// ----- sv/accid_div_stage.sv -----
module accid_div_stage
    import accid_pkg::*;
#(
    parameter int DEN_W = ADC_BITS_DEF + 1,
    parameter int Q_W   = ADC_BITS_DEF + REF_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [Q_W-1:0]   work_in,
    input  logic [DEN_W-1:0] den_in,
    input  res_flags_t       flags_in,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [DEN_W-1:0] rem_out,
    output logic [Q_W-1:0]   work_out,
    output logic [DEN_W-1:0] den_out,
    output res_flags_t       flags_out
);

    logic             valid_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   work_reg;
    logic [DEN_W-1:0] den_reg;
    res_flags_t       flags_reg;
    logic [DEN_W-1:0] rem_next;
    logic [Q_W-1:0]   work_next;

    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           qbit;
        rem_next  = rem_in;
        work_next = work_in;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            trial = {rem_next, work_next[Q_W-1]};
            qbit  = (trial >= {1'b0, den_in});
            if (qbit)
            begin
                trial = trial - {1'b0, den_in};
            end
            rem_next  = trial[DEN_W-1:0];
            work_next = {work_next[Q_W-2:0], qbit};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign work_out  = work_reg;
    assign den_out   = den_reg;
    assign flags_out = flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg   <= rem_next;
            work_reg  <= work_next;
            den_reg   <= den_in;
            flags_reg <= flags_in;
        end
    end

endmodule

// ----- sv/accid_classify.sv -----
module accid_classify
    import accid_pkg::*;
#(
    parameter int Q_W = ADC_BITS_DEF + REF_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [Q_W-1:0]   quotient,
    input  res_flags_t       flags_in,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [RES_W-1:0] resistance,
    output logic [IDX_W-1:0] module_index,
    output logic             divide_fault
);

    localparam int EXT_W = (Q_W > RES_W) ? Q_W : RES_W;

    logic             valid_reg;
    logic [RES_W-1:0] res_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             fault_reg;
    logic [EXT_W-1:0] q_ext;
    logic [RES_W-1:0] res_next;
    logic [IDX_W-1:0] idx_next;

    assign q_ext = EXT_W'(quotient);

    always_comb
    begin
        if (flags_in.fault || flags_in.zero)
        begin
            res_next = '0;
        end
        else if ((q_ext >> RES_W) != '0)
        begin
            res_next = RES_MAX;
        end
        else
        begin
            res_next = q_ext[RES_W-1:0];
        end
        idx_next = classify(res_next);
    end

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign resistance   = res_reg;
    assign module_index = idx_reg;
    assign divide_fault = fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg   <= res_next;
            idx_reg   <= idx_next;
            fault_reg <= flags_in.fault;
        end
    end

    a_fault_clears : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && fault_reg |-> res_reg == '0 && idx_reg == IDX_NONE)
        else $error("fault result carries a nonzero resistance or index");

    a_index_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && idx_reg != IDX_NONE |->
            res_reg > LO_BOUND[0] && res_reg < HI_BOUND[TABLE_LEN-1])
        else $error("module index given for a resistance outside the table");

    a_gap_unmatched : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (res_reg == HI_BOUND[12] || res_reg == LO_BOUND[13]) |->
            idx_reg == IDX_NONE)
        else $error("resistance in the gap between intervals was matched");

    a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted transaction did not reach the output register");

endmodule

// ----- sv/accessory_id_from_divider_top.sv -----
// An input transaction passes through the front register, the divider stages and the classify register.
// Throughput: one transaction per cycle unless stalled; the divider retires two quotient bits per stage.
// Each stage holds its item while the next stage is full, so bubbles are filled under a stall.
// Reset clears all valid bits and sets the reference resistor register to 510.
module accessory_id_from_divider_top
    import accid_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    accid_in_if.sink              sample,
    accid_out_if.source           result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NUM_W    = ADC_BITS + REF_W;
    localparam int DEN_W    = ADC_BITS + 1;
    localparam int N_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int Q_W      = N_STAGES * DIV_STEP;

    logic [REF_W-1:0] ref_res;

    logic             st_valid [N_STAGES+1];
    logic             st_ready [N_STAGES+1];
    logic [DEN_W-1:0] st_rem   [N_STAGES+1];
    logic [Q_W-1:0]   st_work  [N_STAGES+1];
    logic [DEN_W-1:0] st_den   [N_STAGES+1];
    res_flags_t       st_flags [N_STAGES+1];

    accid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ref_res (ref_res)
    );

    accid_front #(
        .ADC_BITS (ADC_BITS),
        .DEN_W    (DEN_W),
        .Q_W      (Q_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .sense     (sample.sense_reading),
        .supply    (sample.supply_reading),
        .ref_res   (ref_res),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .rem_out   (st_rem[0]),
        .work_out  (st_work[0]),
        .den_out   (st_den[0]),
        .flags_out (st_flags[0])
    );

    for (genvar i = 0; i < N_STAGES; i++)
    begin : g_div
        accid_div_stage #(
            .DEN_W (DEN_W),
            .Q_W   (Q_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .rem_in    (st_rem[i]),
            .work_in   (st_work[i]),
            .den_in    (st_den[i]),
            .flags_in  (st_flags[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .rem_out   (st_rem[i+1]),
            .work_out  (st_work[i+1]),
            .den_out   (st_den[i+1]),
            .flags_out (st_flags[i+1])
        );
    end

    accid_classify #(
        .Q_W (Q_W)
    ) u_classify (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (st_valid[N_STAGES]),
        .in_ready     (st_ready[N_STAGES]),
        .quotient     (st_work[N_STAGES]),
        .flags_in     (st_flags[N_STAGES]),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .resistance   (result.resistance),
        .module_index (result.module_index),
        .divide_fault (result.divide_fault)
    );

endmodule

// ----- tb/accid_result_checker.sv -----
`timescale 1ns / 100ps

module accid_result_checker
    import accid_pkg::*;
#(
    parameter int ADC_W = ADC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    accid_in_if                   sample,
    accid_out_if                  result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    pending_results,
    output int                    readings_checked,
    output int                    faults_seen,
    output logic [15:0]           index_seen
);

    typedef struct packed {
        logic [RES_W-1:0] resistance;
        logic [IDX_W-1:0] module_index;
        logic             divide_fault;
    } divider_result_t;

    localparam int unsigned ID_LOW [15] = '{
        43, 51, 62, 75, 91, 110, 135, 165, 200, 245, 300, 360, 430, 516, 620
    };
    localparam int unsigned ID_HIGH [15] = '{
        51, 62, 75, 91, 110, 135, 165, 200, 245, 300, 360, 430, 515, 620, 750
    };

    logic [REF_W-1:0]  ref_ohms;
    divider_result_t   expected_q [$];

    function automatic logic [IDX_W-1:0] table_position_of(input logic [RES_W-1:0] ohms);
        for (int k = 0; k < 15; k++)
        begin
            if (ohms > ID_LOW[k] && ohms < ID_HIGH[k])
            begin
                return IDX_W'(k + 1);
            end
        end
        return '0;
    endfunction

    function automatic divider_result_t predict_divider(input logic [ADC_W-1:0] sense,
                                                        input logic [ADC_W-1:0] supply,
                                                        input logic [REF_W-1:0] rref);
        longint unsigned twice;
        longint unsigned quotient;
        divider_result_t res;
        res = '0;
        twice = 64'(supply) << 1;
        if (twice == 64'(sense))
        begin
            res.divide_fault = 1'b1;
        end
        else if (twice > 64'(sense))
        begin
            quotient = (64'(sense) * 64'(rref)) / (twice - 64'(sense));
            if (quotient > 64'(RES_MAX))
            begin
                quotient = 64'(RES_MAX);
            end
            res.resistance = RES_W'(quotient);
            res.module_index = table_position_of(res.resistance);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        divider_result_t due;
        if (!rst_n)
        begin
            ref_ohms = REF_RESET;
            expected_q.delete();
            mismatches = 0;
            readings_checked = 0;
            faults_seen = 0;
            index_seen = '0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                expected_q.push_back(predict_divider(sample.sense_reading,
                                                     sample.supply_reading, ref_ohms));
            end
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with no reading outstanding");
                    mismatches++;
                end
                else
                begin
                    due = expected_q.pop_front();
                    readings_checked++;
                    if (result.resistance !== due.resistance)
                    begin
                        $error("resistance: expected %0d, actual %0d",
                               due.resistance, result.resistance);
                        mismatches++;
                    end
                    if (result.module_index !== due.module_index)
                    begin
                        $error("module_index: expected %0d, actual %0d",
                               due.module_index, result.module_index);
                        mismatches++;
                    end
                    if (result.divide_fault !== due.divide_fault)
                    begin
                        $error("divide_fault: expected %0d, actual %0d",
                               due.divide_fault, result.divide_fault);
                        mismatches++;
                    end
                    if (due.divide_fault)
                    begin
                        faults_seen++;
                    end
                    index_seen[due.module_index] = 1'b1;
                end
            end
            if (psel && penable && pwrite && pready
                && (paddr >> 2) == CFG_ADDR_W'(REG_IDX_REF))
            begin
                ref_ohms = pwdata[REF_W-1:0];
            end
        end
        pending_results = expected_q.size();
    end

endmodule

// ----- tb/accessory_id_from_divider_top_test.sv -----
`timescale 1ns / 100ps

module accessory_id_from_divider_top_test
    import accid_pkg::*;
();

    localparam int ADC_W = ADC_BITS_DEF;
    localparam int ADC_MAX = (1 << ADC_W) - 1;
    localparam int PIPE_LATENCY = 2 + (ADC_W + REF_W + 1) / 2;
    localparam int REG_IDX_SPARE = 1;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    pending_results;
    int                    readings_checked;
    int                    faults_seen;
    logic [15:0]           index_seen;

    int                    burst_left;
    int                    settings_applied;
    int                    current_ref;
    int                    stall_left;

    accid_in_if #(.ADC_BITS(ADC_W)) sample_if ();
    accid_out_if result_if ();

    accessory_id_from_divider_top #(.ADC_BITS(ADC_W)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    accid_result_checker #(.ADC_W(ADC_W)) checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample           (sample_if),
        .result           (result_if),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .mismatches       (mismatches),
        .pending_results  (pending_results),
        .readings_checked (readings_checked),
        .faults_seen      (faults_seen),
        .index_seen       (index_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("accessory_id_from_divider_top_test: errors");
        $finish;
    end

    // The receiver alternates between long ready stretches, long stalls and choppy patterns.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    result_if.ready <= 1'b1;
                    stall_left <= $urandom_range(20, 80);
                end
                1:
                begin
                    result_if.ready <= 1'b0;
                    stall_left <= $urandom_range(1, 12);
                end
                default:
                begin
                    result_if.ready <= 1'($urandom_range(0, 1));
                    stall_left <= $urandom_range(0, 3);
                end
            endcase
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
    end

    function automatic bit find_reading_pair(input int target, input int rref, input int d_first,
                                             output logic [ADC_W-1:0] sense,
                                             output logic [ADC_W-1:0] supply);
        int cand;
        sense = '0;
        supply = '0;
        if (rref == 0)
        begin
            return 1'b0;
        end
        for (int d = d_first; d <= 2 * ADC_MAX; d++)
        begin
            cand = (target * d + rref - 1) / rref;
            if (cand > ADC_MAX)
            begin
                return 1'b0;
            end
            for (int k = 0; k < 2; k++)
            begin
                if (cand + k <= ADC_MAX && (cand + k) * rref / d == target
                    && (cand + k + d) % 2 == 0 && (cand + k + d) / 2 <= ADC_MAX)
                begin
                    sense = ADC_W'(cand + k);
                    supply = ADC_W'((cand + k + d) / 2);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic offer_reading(input logic [ADC_W-1:0] sense, input logic [ADC_W-1:0] supply);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                sample_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        sample_if.valid <= 1'b1;
        sample_if.sense_reading <= sense;
        sample_if.supply_reading <= supply;
        @(posedge clk);
        while (!sample_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic draw_reading(output logic [ADC_W-1:0] sense, output logic [ADC_W-1:0] supply);
        int d;
        sense = ADC_W'($urandom_range(0, ADC_MAX));
        supply = ADC_W'($urandom_range(0, ADC_MAX));
        case ($urandom_range(0, 7))
            3, 4:
            begin
                if (!find_reading_pair($urandom_range(0, 800), current_ref,
                                       $urandom_range(1, 40), sense, supply))
                begin
                    sense = ADC_W'($urandom_range(0, ADC_MAX));
                    supply = ADC_W'($urandom_range(0, ADC_MAX));
                end
            end
            5:
            begin
                supply = ADC_W'($urandom_range(0, ADC_MAX / 2));
                sense = ADC_W'(2 * supply);
            end
            6:
            begin
                sense = ADC_W'($urandom_range(1, ADC_MAX));
                supply = ADC_W'($urandom_range(0, (sense - 1) / 2));
            end
            7:
            begin
                d = $urandom_range(1, 8);
                supply = ADC_W'($urandom_range((d + 1) / 2, (ADC_MAX + d) / 2));
                sense = ADC_W'(2 * supply - d);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic run_readings(input int count);
        logic [ADC_W-1:0] sense;
        logic [ADC_W-1:0] supply;
        repeat (count)
        begin
            draw_reading(sense, supply);
            offer_reading(sense, supply);
        end
    endtask

    task automatic settle();
        sample_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (pending_results == 0);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_register(input int idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == int'(REG_IDX_REF))
        begin
            current_ref = int'(value[REF_W-1:0]);
            settings_applied++;
        end
    endtask

    initial
    begin
        int boundaries [15];
        int settings [7];
        int counts [7];
        logic [ADC_W-1:0] sense;
        logic [ADC_W-1:0] supply;

        boundaries = '{42, 43, 44, 50, 51, 430, 431, 514, 515, 516, 517, 619, 620, 749, 750};
        settings = '{0, 1, (1 << REF_W) - 1, $urandom_range(2, 4094), $urandom_range(2, 4094),
                     $urandom_range(2, 4094), int'(REF_RESET)};
        counts = '{40, 90, 100, 100, 100, 100, 90};

        rst_n <= 1'b0;
        sample_if.valid <= 1'b0;
        sample_if.sense_reading <= '0;
        sample_if.supply_reading <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        burst_left = 0;
        settings_applied = 1;
        current_ref = int'(REF_RESET);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero and negative denominators, the widest readings and the smallest denominator.
        offer_reading('0, '0);
        offer_reading(ADC_W'(ADC_MAX - 1), ADC_W'((ADC_MAX - 1) / 2));
        offer_reading(ADC_W'(ADC_MAX), '0);
        offer_reading('0, ADC_W'(ADC_MAX));
        offer_reading(ADC_W'(ADC_MAX), ADC_W'(ADC_MAX));
        offer_reading(ADC_W'(ADC_MAX), ADC_W'((ADC_MAX + 1) / 2));
        offer_reading(ADC_W'(1), ADC_W'(1));
        foreach (boundaries[i])
        begin
            if (find_reading_pair(boundaries[i], current_ref, 1, sense, supply))
            begin
                offer_reading(sense, supply);
            end
        end
        run_readings(110);

        foreach (settings[i])
        begin
            settle();
            write_register(int'(REG_IDX_REF), APB_DATA_W'(settings[i]));
            if (i == 2)
            begin
                write_register(REG_IDX_SPARE, APB_DATA_W'($urandom_range(0, 4095)));
            end
            run_readings(counts[i]);
        end

        sample_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
        repeat (PIPE_LATENCY + 8) @(posedge clk);

        $display("Checked %0d results over %0d resistor settings, %0d of them divide faults.",
                 readings_checked, settings_applied, faults_seen);
        $display("Observed %0d of the 16 module index values.", $countones(index_seen));
        if (mismatches == 0 && pending_results == 0)
        begin
            $display("accessory_id_from_divider_top_test: clean");
        end
        else
        begin
            $display("accessory_id_from_divider_top_test: errors");
        end
        $finish;
    end

endmodule
